>>> rtl/core/acmd_pkg.sv
// ----------------------------------------------------------------------------
// acmd_pkg - shared definitions for the modulated delay unit
// Default sizes, field widths, register indexes and fixed-point constants
// used by the delay core and its port checker.
// ----------------------------------------------------------------------------
package acmd_pkg;

  // default sizes
  localparam int DELAY_DEPTH_DEF  = 4096;
  localparam int MAX_CHANNELS_DEF = 2;
  localparam int SINE_ENTRIES_DEF = 1024;

  // word and register widths
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int CHCNT_W   = 2;
  localparam int DLEN_W    = 13;
  localparam int BASE_W    = 12;
  localparam int DEPTH_W   = 12;
  localparam int STEP_W    = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd4;

  // mix gains in q15 (0.7 dry, 0.3 wet)
  localparam logic signed [15:0] MIX_DRY = 16'sd22938;
  localparam logic signed [15:0] MIX_WET = 16'sd9830;

  // sine table generation constants, q30
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned PI_Q30  = 64'd3373259426;

endpackage

>>> rtl/core/audio_chorus_modulated_delay_unit.sv
// ----------------------------------------------------------------------------
// audio_chorus_modulated_delay_unit - chorus / flanger modulated delay line
// Mixes each interleaved pcm word with a delayed copy of its own channel,
// the delay swinging sinusoidally once per frame, and stores the mix back.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one signed 16-bit pcm sample per word, channels interleaved in
//            order; the block counts channels itself.
//   out_*  : one mixed, saturated sample per input word, same order.
//   cfg_*  : register writes (channel count, ring length, base delay,
//            modulation depth, phase step), taken whenever cfg_wr_en is high;
//            write them only while no word is in flight.
// Flow: an accepted word passes the calc step (delay memory read), then the
//   write step (read-modify-write of the same memory port), which commits
//   it into the out_tdata register; the next word is taken at that commit at
//   the earliest. When it is not offered right at the end of a frame, the
//   delay multiplier path must settle first, so that word waits in idle.
// Reset: rst_n restores the registers and clears the delay memory one entry
//   per cycle, all MAX_CHANNELS * DELAY_DEPTH entries (8192 at the defaults);
//   in_tready stays low meanwhile, configuration writes are taken.
// Stall: the result sits in an output register; a stalled receiver holds
//   the word in flight in its write step until the register frees up.
// ----------------------------------------------------------------------------
module audio_chorus_modulated_delay_unit #(
  parameter int DELAY_DEPTH  = acmd_pkg::DELAY_DEPTH_DEF,
  parameter int MAX_CHANNELS = acmd_pkg::MAX_CHANNELS_DEF,
  parameter int SINE_ENTRIES = acmd_pkg::SINE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [acmd_pkg::SAMPLE_W-1:0]  in_tdata,    // [15:0] sample_in
  // output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [acmd_pkg::SAMPLE_W-1:0]  out_tdata,   // [15:0] sample_out
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [acmd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acmd_pkg::CFG_W-1:0]     cfg_data
);
  import acmd_pkg::*;

  localparam int MEM_DEPTH = MAX_CHANNELS * DELAY_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int POS_W     = $clog2(DELAY_DEPTH);
  localparam int LEN_W     = $clog2(DELAY_DEPTH + 1);
  localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W     = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W     = $clog2(SINE_ENTRIES);
  localparam int ENT_W     = IDX_W - 1;
  localparam int QUARTER   = SINE_ENTRIES / 4;
  localparam int PROD_W    = DEPTH_W + 1 + SAMPLE_W;

  localparam logic [1:0] SETTLE_FRESH = 2'd2;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_WRITE} state_t;
  typedef logic [14:0] sine_tab_t [QUARTER+1];

  // quarter-wave sine, taylor series through x^11 in q30, scaled to q15
  function automatic logic [14:0] quarter_sine(input longint unsigned j);
    longint unsigned x, x2, t, s, v;
    x  = (PI_Q30 * j) / (2 * QUARTER);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    v  = (s * 32767 + (64'd1 << 29)) >> 30;
    if (v > 32767) v = 32767;
    return 15'(v);
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i <= QUARTER; i++) begin
      tab[i] = quarter_sine(longint'(i));
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // full-wave lookup from the top phase bits, mirrored by quadrant
  function automatic logic signed [15:0] sine_at(input logic [31:0] ph);
    logic [IDX_W-1:0] idx;
    logic [ENT_W-1:0] ent;
    logic [15:0]      mag;
    idx = ph[31 -: IDX_W];
    if (idx[IDX_W-2]) begin
      ent = ENT_W'(QUARTER) - {1'b0, idx[IDX_W-3:0]};
    end else begin
      ent = {1'b0, idx[IDX_W-3:0]};
    end
    mag = {1'b0, SINE_TAB[ent]};
    return idx[IDX_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

  // configuration registers
  logic [CHCNT_W-1:0] chan_count_r;
  logic [DLEN_W-1:0]  dly_len_r;
  logic [BASE_W-1:0]  base_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [STEP_W-1:0]  step_r;

  // derived limits
  logic [LEN_W-1:0] len_r;
  logic [NCH_W-1:0] nch_r;

  // control state
  state_t            state_r;
  logic [ADDR_W-1:0] clr_r;
  logic [1:0]        settle_r;
  logic [POS_W-1:0]  wpos_r;
  logic [CH_W-1:0]   chan_cnt_r;
  logic [31:0]       phase_r;
  logic [LEN_W-1:0]  frame_delay_r;
  logic              out_tvalid_r;

  // per-word registers
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [ADDR_W-1:0]          wr_addr_r;
  logic [POS_W-1:0]           pos_r;
  logic [CH_W-1:0]            ch_r;
  logic                       frame_end_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;

  // modulation path: current phase and look-ahead to the next frame
  logic signed [SAMPLE_W-1:0] sine_c_r, sine_a_r;
  logic signed [PROD_W-1:0]   prod_c_r, prod_a_r;

  // delay memory
  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [SAMPLE_W-1:0] mem_q_r;

  // handshake helpers
  logic in_acc, out_free, commit;

  // combinational address and mix
  logic [CH_W-1:0]            ch;
  logic [POS_W-1:0]           pos;
  logic signed [PROD_W-1:0]   prod_sel;
  logic signed [13:0]         swing;
  logic signed [14:0]         total;
  logic [LEN_W-1:0]           fd_new, d;
  logic [LEN_W:0]             rd_sum;
  logic [POS_W-1:0]           rd;
  logic [ADDR_W-1:0]          rd_addr, wr_addr;
  logic                       frame_end;
  logic signed [31:0]         acc, acc_adj;
  logic signed [16:0]         y_wide;
  logic [SAMPLE_W-1:0]        y;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr;
  logic signed [SAMPLE_W-1:0] mem_wdata;

  assign out_free  = !out_tvalid_r || out_tready;
  assign commit    = (state_r == S_WRITE) && out_free;
  assign in_tready = ((state_r == S_IDLE) && (settle_r != SETTLE_FRESH)) || commit;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // frame delay and ring addresses for the word in calc
  always_comb begin
    ch  = (32'(chan_cnt_r) >= 32'(nch_r)) ? '0 : chan_cnt_r;
    pos = (32'(wpos_r) < 32'(len_r)) ? wpos_r : '0;
    prod_sel = (settle_r == SETTLE_FRESH) ? prod_a_r : prod_c_r;
    swing = prod_sel[PROD_W-1 -: 14];
    total = $signed({3'b000, base_r}) + $signed({swing[13], swing});
    if (total[14]) begin
      fd_new = '0;
    end else if (32'(total) > 32'(len_r)) begin
      fd_new = len_r;
    end else begin
      fd_new = LEN_W'(total[13:0]);
    end
    if (ch == '0) begin
      d = fd_new;
    end else if (frame_delay_r > len_r) begin
      d = len_r;
    end else begin
      d = frame_delay_r;
    end
    rd_sum = (LEN_W+1)'(pos) + {1'b0, len_r} - {1'b0, d};
    if (rd_sum >= {1'b0, len_r}) begin
      rd = POS_W'(rd_sum - {1'b0, len_r});
    end else begin
      rd = POS_W'(rd_sum);
    end
    rd_addr   = ADDR_W'(32'(ch) * DELAY_DEPTH) + ADDR_W'(rd);
    wr_addr   = ADDR_W'(32'(ch) * DELAY_DEPTH) + ADDR_W'(pos);
    frame_end = (32'(ch) + 1) >= 32'(nch_r);
  end

  // dry/wet mix, truncated toward zero, saturated
  always_comb begin
    acc     = 32'(sample_r) * 32'(MIX_DRY) + 32'(mem_q_r) * 32'(MIX_WET);
    acc_adj = acc + (acc[31] ? 32'sd32767 : 32'sd0);
    y_wide  = acc_adj[31:15];
    if (y_wide > 17'sd32767) begin
      y = 16'h7fff;
    end else if (y_wide < -17'sd32768) begin
      y = 16'h8000;
    end else begin
      y = y_wide[15:0];
    end
  end

  // memory write port: clearing pass or committed mix
  always_comb begin
    mem_we    = (state_r == S_CLEAR) || commit;
    mem_waddr = (state_r == S_CLEAR) ? clr_r : wr_addr_r;
    mem_wdata = (state_r == S_CLEAR) ? '0 : $signed(y);
  end

  // delay memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == S_CALC) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // modulation multipliers, recomputed every cycle
  always_ff @(posedge clk) begin
    sine_c_r <= sine_at(phase_r);
    sine_a_r <= sine_at(phase_r + step_r);
    prod_c_r <= $signed({1'b0, depth_r}) * sine_c_r;
    prod_a_r <= $signed({1'b0, depth_r}) * sine_a_r;
  end

  // clamped limits
  always_ff @(posedge clk) begin
    if (dly_len_r == '0) begin
      len_r <= LEN_W'(1);
    end else if (32'(dly_len_r) > 32'(DELAY_DEPTH)) begin
      len_r <= LEN_W'(DELAY_DEPTH);
    end else begin
      len_r <= LEN_W'(dly_len_r);
    end
    if (chan_count_r == '0) begin
      nch_r <= NCH_W'(1);
    end else if (32'(chan_count_r) > 32'(MAX_CHANNELS)) begin
      nch_r <= NCH_W'(MAX_CHANNELS);
    end else begin
      nch_r <= NCH_W'(chan_count_r);
    end
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_count_r <= CHCNT_W'(1);
      dly_len_r    <= DLEN_W'(4096);
      base_r       <= '0;
      depth_r      <= '0;
      step_r       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: chan_count_r <= cfg_data[CHCNT_W-1:0];
        REG_DELAY_LENGTH:  dly_len_r    <= cfg_data[DLEN_W-1:0];
        REG_BASE_DELAY:    base_r       <= cfg_data[BASE_W-1:0];
        REG_MOD_DEPTH:     depth_r      <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_STEP:    step_r       <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // per-word capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= $signed(in_tdata);
    end
    if (state_r == S_CALC) begin
      wr_addr_r   <= wr_addr;
      pos_r       <= pos;
      ch_r        <= ch;
      frame_end_r <= frame_end;
    end
  end

  // sequencer, ring state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      settle_r      <= '0;
      wpos_r        <= '0;
      chan_cnt_r    <= '0;
      phase_r       <= '0;
      frame_delay_r <= '0;
      out_tvalid_r  <= 1'b0;
      out_tdata_r   <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + ADDR_W'(1);
          if (32'(clr_r) == MEM_DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CALC;
          end
        end
        S_CALC: begin
          if (ch == '0) begin
            frame_delay_r <= fd_new;
          end
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (commit) begin
            state_r <= in_acc ? S_CALC : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // ring position, channel and phase advance at commit
      if (commit) begin
        if (frame_end_r) begin
          chan_cnt_r <= '0;
          wpos_r     <= (32'(pos_r) + 1 >= 32'(len_r)) ? '0 : pos_r + POS_W'(1);
          phase_r    <= phase_r + step_r;
        end else begin
          chan_cnt_r <= ch_r + CH_W'(1);
          wpos_r     <= pos_r;
        end
      end

      // modulation path settling after a phase step
      if (commit && frame_end_r) begin
        settle_r <= SETTLE_FRESH;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end

      // output register
      if (commit) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= y;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/acmd_checker.sv
// ----------------------------------------------------------------------------
// acmd_checker - port-level checks for the modulated delay unit
// Watches the stream ports over time and flags ordering or hold violations.
// ----------------------------------------------------------------------------
module acmd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [acmd_pkg::SAMPLE_W-1:0] out_tdata
);
  import acmd_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed or dropped while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // the word just taken is still being worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("new word taken while the previous one is in calc");

  // every accepted word has a result word waiting on the output later
  a_result_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##3 out_tvalid)
    else $error("no result word after an accepted word");

endmodule

bind audio_chorus_modulated_delay_unit acmd_checker u_acmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/audio_chorus_modulated_delay_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_chorus_modulated_delay_unit_tb - self-checking bench for the chorus unit
// Streams interleaved pcm words through the modulated delay line under random
// gaps and back-pressure, keeps its own copy of the delay rings, sine table
// and frame state to predict every mixed word, and compares each output word
// in order. Settings sweep channel count, ring length, base delay, depth and
// phase step, including out-of-range values and changes in mid-frame.
// ----------------------------------------------------------------------------
module audio_chorus_modulated_delay_unit_tb;
  import acmd_pkg::*;

  localparam int CLK_HALF    = 5;
  // covers the reset clear of all 8192 ring entries and ~1100 words; wide margin
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_CH        = MAX_CHANNELS_DEF;
  localparam int N_RING      = DELAY_DEPTH_DEF;
  localparam int N_SINE      = SINE_ENTRIES_DEF;
  localparam int SINE_SHIFT  = 32 - $clog2(N_SINE);
  localparam int N_PHASES    = 9;

  // tracks the delay rings and frame state, holds the mixed words to come
  class chorus_mix_tracker;
    logic [CHCNT_W-1:0]         chan_count_r;
    logic [DLEN_W-1:0]          ring_len_r;
    logic [BASE_W-1:0]          base_r;
    logic [DEPTH_W-1:0]         depth_r;
    logic [STEP_W-1:0]          step_r;
    logic signed [SAMPLE_W-1:0] ring [N_CH][N_RING];
    int                         sine_q15 [N_SINE];
    logic [11:0]                wr_pos;
    logic [31:0]                phase_acc;
    logic                       chan_idx;
    logic [DLEN_W-1:0]          frame_dly;
    logic [SAMPLE_W-1:0]        expected_mix [$];
    int                         mismatch_count;

    function new();
      for (int i = 0; i < N_SINE; i++) sine_q15[i] = sine_entry(i);
      mismatch_count = 0;
      chan_count_r = 1;
      ring_len_r   = N_RING;
      base_r       = '0;
      depth_r      = '0;
      step_r       = '0;
      wr_pos       = '0;
      phase_acc    = '0;
      chan_idx     = 1'b0;
      frame_dly    = '0;
      foreach (ring[c, k]) ring[c][k] = '0;
    endfunction

    // quarter wave in q30, horner taylor series through x^11, scaled to q15
    function int quarter_wave(longint unsigned j, longint unsigned quarter);
      longint unsigned x, x2, t, s, v;
      if (quarter == 0) return 0;
      x  = (PI_Q30 * j) / (2 * quarter);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      return int'(v);
    endfunction

    // full wave built from the quarter by quadrant
    function int sine_entry(int idx);
      int quarter, quad, j;
      quarter = N_SINE / 4;
      quad    = (idx / quarter) & 3;
      j       = idx % quarter;
      case (quad)
        0:       return  quarter_wave(j, quarter);
        1:       return  quarter_wave(quarter - j, quarter);
        2:       return -quarter_wave(j, quarter);
        default: return -quarter_wave(quarter - j, quarter);
      endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_CHANNEL_COUNT: chan_count_r = data[CHCNT_W-1:0];
        REG_DELAY_LENGTH:  ring_len_r   = data[DLEN_W-1:0];
        REG_BASE_DELAY:    base_r       = data[BASE_W-1:0];
        REG_MOD_DEPTH:     depth_r      = data[DEPTH_W-1:0];
        REG_PHASE_STEP:    step_r       = data[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted word: frame delay, ring read, mix, ring write
    function void accept_sample(logic signed [SAMPLE_W-1:0] x);
      int len, nch, ch, pos, d, rd, prod, swing, total, acc, y;
      len = int'(ring_len_r);
      if (len == 0) len = 1;
      if (len > N_RING) len = N_RING;
      nch = int'(chan_count_r);
      if (nch == 0) nch = 1;
      if (nch > N_CH) nch = N_CH;
      ch = (int'(chan_idx) >= nch) ? 0 : int'(chan_idx);

      // new delay at the first channel of a frame, floor of the swing
      if (ch == 0) begin
        prod = int'(depth_r) * sine_q15[int'(phase_acc >> SINE_SHIFT)];
        if (prod >= 0) swing = prod / 32768;
        else swing = -((-prod + 32767) / 32768);
        total = int'(base_r) + swing;
        if (total < 0) total = 0;
        if (total > len) total = len;
        frame_dly = DLEN_W'(total);
      end

      // ring may have shrunk since the last frame
      pos    = (int'(wr_pos) < len) ? int'(wr_pos) : 0;
      wr_pos = 12'(pos);
      d      = (int'(frame_dly) > len) ? len : int'(frame_dly);
      rd     = pos + len - d;
      if (rd >= len) rd -= len;

      acc = int'(MIX_DRY) * int'(x) + int'(MIX_WET) * int'(ring[ch][rd]);
      y   = acc / 32768;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      ring[ch][pos] = SAMPLE_W'(y);
      expected_mix.insert(expected_mix.size(), SAMPLE_W'(y));

      // frame end advances the write slot and the phase
      if (ch + 1 >= nch) begin
        chan_idx  = 1'b0;
        wr_pos    = (pos + 1 >= len) ? 12'd0 : 12'(pos + 1);
        phase_acc = phase_acc + step_r;
      end else begin
        chan_idx = 1'b1;
      end
    endfunction

    task report(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_mix(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      if (expected_mix.size() == 0) begin
        report($sformatf("sample_out %0d with no word expected", $signed(got)));
        return;
      end
      want = expected_mix.pop_front();
      if (got !== want)
        report($sformatf("sample_out got %0d want %0d", $signed(got), $signed(want)));
    endtask
  endclass

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [SAMPLE_W-1:0]  in_tdata   = '0;   // [15:0] sample_in
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [SAMPLE_W-1:0]  out_tdata;         // [15:0] sample_out
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  int                cycle_count  = 0;
  int                send_gap_pct = 16;
  int                recv_gap_pct = 62;
  chorus_mix_tracker mix_tracker;

  audio_chorus_modulated_delay_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // cycle count and output word check
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) mix_tracker.check_mix(out_tdata);
  end

  // receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  // mostly full-scale random, some extremes and some near zero
  function automatic logic [SAMPLE_W-1:0] rand_word();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return SAMPLE_W'($urandom_range(0, 15) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [SAMPLE_W-1:0] word);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    mix_tracker.accept_sample(signed'(word));
    @(negedge clk);
  endtask

  // stop sending and let every expected word come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (mix_tracker.expected_mix.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // one register write; random junk above the field width now and then
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    logic [CFG_W-1:0] junk;
    int               w;
    case (idx)
      REG_CHANNEL_COUNT: w = CHCNT_W;
      REG_DELAY_LENGTH:  w = DLEN_W;
      REG_BASE_DELAY:    w = BASE_W;
      REG_MOD_DEPTH:     w = DEPTH_W;
      default:           w = CFG_W;
    endcase
    junk = ($urandom_range(3) == 0 && w < CFG_W) ? CFG_W'($urandom << w) : '0;
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value | junk;
    mix_tracker.set_reg(idx, value | junk);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [CFG_W-1:0] n_ch, input logic [CFG_W-1:0] len,
                              input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] depth,
                              input logic [CFG_W-1:0] step);
    cfg_write(REG_CHANNEL_COUNT, n_ch);
    cfg_write(REG_DELAY_LENGTH, len);
    cfg_write(REG_BASE_DELAY, base);
    cfg_write(REG_MOD_DEPTH, depth);
    cfg_write(REG_PHASE_STEP, step);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    mix_tracker = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: zero delay reads the slot about to be overwritten
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h0001);
    wait_idle();

    // two channels on a one-frame ring
    apply_config(2, 1, 0, 0, 0);
    send_word(16'h7FFF);
    send_word(16'h7FFF);
    send_word(16'h8000);
    send_word(16'h8000);
    wait_idle();

    // channel count above maximum, base delay far past the ring
    apply_config(3, 3, 4095, 0, 0);
    repeat (4) send_word(rand_word());
    wait_idle();

    // zero channel count, oversize ring, full depth through all quadrants
    apply_config(0, 8191, 2, 4095, 32'h4000_0000);
    repeat (4) send_word(rand_word());
    wait_idle();

    // zero ring length
    apply_config(1, 0, 0, 0, 32'hFFFF_FFFF);
    repeat (2) send_word(rand_word());
    wait_idle();

    // channel count cut to one in mid-frame
    apply_config(2, 16, 3, 2, 32'h0123_4567);
    send_word(rand_word());
    wait_idle();
    apply_config(1, 16, 3, 2, 32'h0123_4567);
    repeat (2) send_word(rand_word());
    wait_idle();

    // random settings per phase, lengths mostly short so the rings wrap
    for (int ph = 0; ph < N_PHASES; ph++) begin
      logic [CFG_W-1:0] r_ch, r_len, r_base, r_depth, r_step;
      int               n_words;
      if (ph < N_PHASES / 3) begin
        send_gap_pct = 16;
        recv_gap_pct = 62;
      end else if (ph < 2 * N_PHASES / 3) begin
        send_gap_pct = 62;
        recv_gap_pct = 16;
      end else begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      r_ch = $urandom_range(0, 3);
      case ($urandom_range(9))
        0:       r_len = 0;
        1:       r_len = 1;
        2:       r_len = N_RING;
        3:       r_len = 8191;
        4:       r_len = $urandom_range(2, N_RING - 1);
        default: r_len = $urandom_range(2, 40);
      endcase
      case ($urandom_range(5))
        0:       r_base = 0;
        1:       r_base = 4095;
        default: r_base = $urandom_range(0, 40);
      endcase
      case ($urandom_range(5))
        0:       r_depth = 0;
        1:       r_depth = 4095;
        default: r_depth = $urandom_range(0, 40);
      endcase
      case ($urandom_range(5))
        0:       r_step = 0;
        1:       r_step = 32'hFFFF_FFFF;
        2:       r_step = $urandom;
        default: r_step = $urandom >> $urandom_range(4, 28);
      endcase
      apply_config(r_ch, r_len, r_base, r_depth, r_step);
      n_words = $urandom_range(100, 140);
      for (int k = 0; k < n_words; k++) begin
        // one hold-off until the pipeline has fully drained
        if (ph == N_PHASES / 2 && k == n_words / 2) wait_idle();
        send_word(rand_word());
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mix_tracker.expected_mix.size() != 0)
      mix_tracker.report($sformatf("%0d words never came out",
                                   mix_tracker.expected_mix.size()));
    if (mix_tracker.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/acmd_pkg.sv
rtl/core/audio_chorus_modulated_delay_unit.sv
rtl/core/acmd_checker.sv
tb/audio_chorus_modulated_delay_unit_tb.sv
